FILE: src/video_unit_register_port_and_vram_map_core_assert.svh
// Assertion macros for the video unit register port
`ifndef VIDEO_UNIT_REGISTER_PORT_AND_VRAM_MAP_CORE_ASSERT_SVH
`define VIDEO_UNIT_REGISTER_PORT_AND_VRAM_MAP_CORE_ASSERT_SVH
`define VU_ASSERT_IMPL(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define VU_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

FILE: src/vurp_pkg.sv
// -----------------------------------------------------------------------------
// vurp_pkg
// Types and codes shared by the register port and video memory map.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
package vurp_pkg;
    typedef enum logic [1:0] {
        OP_READ = 2'd0, OP_WRITE = 2'd1, OP_VBL_SET = 2'd2, OP_VBL_CLR = 2'd3
    } t_op;

    localparam logic [2:0] REG_CTRL = 3'd0;
    localparam logic [2:0] REG_MASK = 3'd1;
    localparam logic [2:0] REG_STATUS = 3'd2;
    localparam logic [2:0] REG_OAMADDR = 3'd3;
    localparam logic [2:0] REG_OAMDATA = 3'd4;
    localparam logic [2:0] REG_SCROLL = 3'd5;
    localparam logic [2:0] REG_ADDR = 3'd6;
    localparam logic [2:0] REG_DATA = 3'd7;

    typedef struct packed {
        logic [1:0] opcode;
        logic [2:0] reg_index;
        logic [7:0] write_data;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       nmi_raise;
    } t_out_item;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0, BK_MEM = 2'd1, BK_OUT = 2'd2
    } t_bk_state;
endpackage

FILE: src/vurp_front.sv
// -----------------------------------------------------------------------------
// vurp_front
// Input stage: takes items and holds them in a two-entry queue for the back end.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
module vurp_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  vurp_pkg::t_in_item i_item,
    output logic               o_q_valid,
    output vurp_pkg::t_in_item o_q_item,
    input  logic               i_q_pop
);
    vurp_pkg::t_in_item r_mem [2];
    logic r_wp, n_wp, r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    logic push;

    assign o_stall   = (r_cnt == 2'd2);
    assign push      = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp ^ push;
        n_rp  = r_rp ^ i_q_pop;
        n_cnt = r_cnt + {1'b0, push} - {1'b0, i_q_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp <= n_wp;
            r_rp <= n_rp;
            r_cnt <= n_cnt;
        end
        if (push) begin
            r_mem[r_wp] <= i_item;
        end
    end
endmodule

FILE: src/vurp_back.sv
// -----------------------------------------------------------------------------
// vurp_back
// Execution: register file, address latch, video memories and result register.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
module vurp_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [1:0]          i_mirror,
    input  logic                i_q_valid,
    input  vurp_pkg::t_in_item  i_q_item,
    output logic                o_q_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output vurp_pkg::t_out_item o_item
);
    logic [7:0] r_pat [8192];
    logic [7:0] r_nt [2048];
    logic [7:0] r_pal [32];
    logic [7:0] r_oam [256];

    vurp_pkg::t_bk_state r_st, n_st;
    logic [7:0]  r_ctrl, r_mask, r_buf, r_oaddr;
    logic [2:0]  r_stat, r_fx;
    logic [14:0] r_v, r_t;
    logic        r_w;
    logic [7:0]  r_rd;
    logic        r_nmi;
    logic [1:0]  r_sel;
    logic [7:0]  r_pat_q, r_nt_q, r_pal_q, r_oam_q;

    vurp_pkg::t_in_item it;
    logic [13:0] a;
    logic [10:0] nt_a;
    logic [4:0]  pal_a;
    logic        page, is_wr, dat;
    logic [7:0]  mem_q;

    assign it    = i_q_item;
    assign a     = r_v[13:0];
    assign is_wr = vurp_pkg::t_op'(it.opcode) == vurp_pkg::OP_WRITE;
    assign dat   = it.reg_index == vurp_pkg::REG_DATA;

    always_comb begin
        unique case (i_mirror)
            2'd0: page = a[11];
            2'd1: page = a[10];
            2'd2: page = 1'b0;
            default: page = 1'b1;
        endcase
        nt_a  = {page, a[9:0]};
        pal_a = (a[4] && a[1:0] == 2'b00) ? {1'b0, a[3:0]} : a[4:0];
    end

    always_comb begin
        unique case (r_sel)
            2'd0: mem_q = r_pat_q;
            2'd1: mem_q = r_nt_q;
            default: mem_q = r_pal_q & (r_mask[0] ? 8'h30 : 8'h3F);
        endcase
    end

    assign o_valid = (r_st == vurp_pkg::BK_OUT);
    assign o_item  = '{read_data: r_rd, nmi_raise: r_nmi};

    always_comb begin
        n_st = r_st;
        o_q_pop = 1'b0;
        unique case (r_st)
            vurp_pkg::BK_IDLE: if (i_q_valid) begin
                n_st = vurp_pkg::BK_MEM;
            end
            vurp_pkg::BK_MEM: begin
                n_st = vurp_pkg::BK_OUT;
                o_q_pop = 1'b1;
            end
            vurp_pkg::BK_OUT: if (!i_stall) begin
                n_st = vurp_pkg::BK_IDLE;
            end
            default: n_st = vurp_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_st == vurp_pkg::BK_IDLE) begin
            r_pat_q <= r_pat[a[12:0]];
            r_nt_q  <= r_nt[nt_a];
            r_pal_q <= r_pal[pal_a];
            r_oam_q <= r_oam[r_oaddr];
            r_sel   <= !a[13] ? 2'd0 : (a[13:8] != 6'h3F) ? 2'd1 : 2'd2;
        end
        if (r_st == vurp_pkg::BK_MEM && is_wr && it.reg_index == vurp_pkg::REG_OAMDATA) begin
            r_oam[r_oaddr] <= it.write_data;
        end
        if (r_st == vurp_pkg::BK_MEM && is_wr && dat) begin
            if (!a[13]) begin
                r_pat[a[12:0]] <= it.write_data;
            end else if (a[13:8] != 6'h3F) begin
                r_nt[nt_a] <= it.write_data;
            end else begin
                r_pal[pal_a] <= it.write_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= vurp_pkg::BK_IDLE;
            r_ctrl <= '0; r_mask <= '0; r_buf <= '0; r_oaddr <= '0;
            r_stat <= '0; r_fx <= '0; r_v <= '0; r_t <= '0; r_w <= 1'b0;
            r_rd <= '0; r_nmi <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_st == vurp_pkg::BK_MEM) begin
                r_rd <= '0;
                r_nmi <= 1'b0;
                unique case (vurp_pkg::t_op'(it.opcode))
                    vurp_pkg::OP_READ: begin
                        unique case (it.reg_index)
                            vurp_pkg::REG_STATUS: begin
                                r_rd <= {r_stat, r_buf[4:0]};
                                r_stat[2] <= 1'b0;
                                r_w <= 1'b0;
                            end
                            vurp_pkg::REG_OAMADDR: r_rd <= r_oaddr;
                            vurp_pkg::REG_OAMDATA: r_rd <= r_oam_q;
                            vurp_pkg::REG_DATA: begin
                                r_rd <= (r_sel == 2'd2) ? mem_q : r_buf;
                                r_buf <= mem_q;
                                r_v <= r_v + (r_ctrl[2] ? 15'd32 : 15'd1);
                            end
                            default: r_rd <= '0;
                        endcase
                    end
                    vurp_pkg::OP_WRITE: begin
                        unique case (it.reg_index)
                            vurp_pkg::REG_CTRL: begin
                                r_ctrl <= it.write_data;
                                r_t[11:10] <= it.write_data[1:0];
                            end
                            vurp_pkg::REG_MASK: r_mask <= it.write_data;
                            vurp_pkg::REG_OAMADDR: r_oaddr <= it.write_data;
                            vurp_pkg::REG_OAMDATA: r_oaddr <= r_oaddr + 8'd1;
                            vurp_pkg::REG_SCROLL: begin
                                if (!r_w) begin
                                    r_fx <= it.write_data[2:0];
                                    r_t[4:0] <= it.write_data[7:3];
                                end else begin
                                    r_t[14:12] <= it.write_data[2:0];
                                    r_t[9:5] <= it.write_data[7:3];
                                end
                                r_w <= !r_w;
                            end
                            vurp_pkg::REG_ADDR: begin
                                if (!r_w) begin
                                    r_t[14:8] <= {1'b0, it.write_data[5:0]};
                                end else begin
                                    r_t[7:0] <= it.write_data;
                                    r_v <= {r_t[14:8], it.write_data};
                                end
                                r_w <= !r_w;
                            end
                            vurp_pkg::REG_DATA:
                                r_v <= r_v + (r_ctrl[2] ? 15'd32 : 15'd1);
                            default: r_w <= r_w;
                        endcase
                    end
                    vurp_pkg::OP_VBL_SET: begin
                        r_stat[2] <= 1'b1;
                        r_nmi <= r_ctrl[7];
                    end
                    default: r_stat <= '0;
                endcase
            end
        end
    end
endmodule

FILE: src/video_unit_register_port_and_vram_map_core.sv
// -----------------------------------------------------------------------------
// video_unit_register_port_and_vram_map_core
// CPU register port of a tile video unit with its video memory map.
// -----------------------------------------------------------------------------
// channel | dir | handshake
// in      | in  | i_in_valid / o_in_stall, i_in_item
// out     | out | o_out_valid / i_out_stall, o_out_item
// cfg     | in  | i_cfg_valid / o_cfg_ready, i_cfg_data
// Each item passes three back-end steps in order: memory read, update, result.
// The front queue holds two items; synchronous reset, no clearing pass.
// A stalled result holds the back end; the queue keeps taking items until it is full.
`timescale 1ns / 1ps
module video_unit_register_port_and_vram_map_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  vurp_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output vurp_pkg::t_out_item o_out_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_data
);
    logic [1:0] r_mirror_mode;
    logic q_valid, q_pop;
    vurp_pkg::t_in_item q_item;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mirror_mode <= 2'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mirror_mode <= i_cfg_data;
        end
    end

    vurp_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(i_in_valid), .o_stall(o_in_stall), .i_item(i_in_item),
        .o_q_valid(q_valid), .o_q_item(q_item), .i_q_pop(q_pop)
    );

    vurp_back u_back (
        .i_clk, .i_rst_n, .i_mirror(r_mirror_mode),
        .i_q_valid(q_valid), .i_q_item(q_item), .o_q_pop(q_pop),
        .o_valid(o_out_valid), .i_stall(i_out_stall), .o_item(o_out_item)
    );
endmodule

FILE: src/vurp_checker.sv
// -----------------------------------------------------------------------------
// vurp_checker
// Port checks for the register port.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "video_unit_register_port_and_vram_map_core_assert.svh"
module vurp_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input vurp_pkg::t_out_item o_out_item,
    input logic                o_cfg_ready
);
    `VU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_item))
    `VU_ASSERT_NEXT(a_no_b2b, i_clk, i_rst_n, o_out_valid && !i_out_stall, !o_out_valid)
    `VU_ASSERT_IMPL(a_cfg_rdy, i_clk, i_rst_n, 1'b1, o_cfg_ready)
endmodule

bind video_unit_register_port_and_vram_map_core vurp_checker u_chk (.*);

FILE: verif/testbench.sv
// -----------------------------------------------------------------------------
// testbench
// Self-checking bench for the video unit register port and video memory map.
// A behavioural copy of the register port predicts every result as bus items
// are queued; a clocked driver presents the items with random gaps, a clocked
// monitor checks the results in order under random output stalls. The run
// walks all four nametable mirroring modes.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 170;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    vurp_pkg::t_in_item  i_in_item;
    logic                o_out_valid;
    logic                i_out_stall;
    vurp_pkg::t_out_item o_out_item;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [1:0]          i_cfg_data;

    video_unit_register_port_and_vram_map_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_item(i_in_item),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_item(o_out_item),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    // shadow of the register port
    logic [1:0]  mirror_sel;
    logic [7:0]  ctrl_q, mask_q, rbuf_q, oam_addr_q;
    logic [2:0]  status_q, fine_x_q;
    logic [14:0] vcur_q, vtmp_q;
    logic        toggle_q;
    logic [7:0]  oam_mem [256];
    logic [7:0]  pat_mem [8192];
    logic [7:0]  nt_mem [2048];
    logic [7:0]  pal_mem [32];
    bit          oam_seen [256];
    bit          pat_seen [8192];
    bit          nt_seen [2048];
    bit          pal_seen [32];

    vurp_pkg::t_in_item  bus_items[$];
    vurp_pkg::t_out_item expected_results[$];

    int  errors, items_queued, results_checked, cycles, nmi_count;
    bit  calm;
    bit  in_taken;
    int  in_gap, out_gap;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("video_unit_register_port_and_vram_map_core test failed");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic logic [10:0] nt_slot(logic [13:0] a);
        logic page;
        case (mirror_sel)
            2'd0: page = a[11];
            2'd1: page = a[10];
            2'd2: page = 1'b0;
            default: page = 1'b1;
        endcase
        return {page, a[9:0]};
    endfunction

    function automatic logic [4:0] pal_slot(logic [13:0] a);
        logic [4:0] i;
        i = a[4:0];
        if (i[4] && i[1:0] == 2'b00) i[4] = 1'b0;
        return i;
    endfunction

    function automatic bit vram_known(logic [13:0] a);
        if (a < 14'h2000) return pat_seen[a[12:0]];
        if (a < 14'h3F00) return nt_seen[nt_slot(a)];
        return pal_seen[pal_slot(a)];
    endfunction

    function automatic logic [7:0] vram_load(logic [13:0] a);
        if (a < 14'h2000) return pat_mem[a[12:0]];
        if (a < 14'h3F00) return nt_mem[nt_slot(a)];
        return pal_mem[pal_slot(a)] & (mask_q[0] ? 8'h30 : 8'h3F);
    endfunction

    function automatic void vram_store(logic [13:0] a, logic [7:0] d);
        if (a < 14'h2000) begin
            pat_mem[a[12:0]] = d;
            pat_seen[a[12:0]] = 1'b1;
        end else if (a < 14'h3F00) begin
            nt_mem[nt_slot(a)] = d;
            nt_seen[nt_slot(a)] = 1'b1;
        end else begin
            pal_mem[pal_slot(a)] = d;
            pal_seen[pal_slot(a)] = 1'b1;
        end
    endfunction

    function automatic void step_vaddr();
        vcur_q = vcur_q + (ctrl_q[2] ? 15'd32 : 15'd1);
    endfunction

    function automatic vurp_pkg::t_out_item port_access(vurp_pkg::t_in_item it);
        vurp_pkg::t_out_item res;
        logic [13:0] a;
        logic [7:0] d;
        res = '0;
        d = it.write_data;
        a = vcur_q[13:0];
        case (it.opcode)
            vurp_pkg::OP_READ: begin
                case (it.reg_index)
                    vurp_pkg::REG_STATUS: begin
                        res.read_data = {status_q, rbuf_q[4:0]};
                        status_q[2] = 1'b0;
                        toggle_q = 1'b0;
                    end
                    vurp_pkg::REG_OAMADDR: res.read_data = oam_addr_q;
                    vurp_pkg::REG_OAMDATA: res.read_data = oam_mem[oam_addr_q];
                    vurp_pkg::REG_DATA: begin
                        res.read_data = rbuf_q;
                        rbuf_q = vram_load(a);
                        if (a >= 14'h3F00) res.read_data = rbuf_q;
                        step_vaddr();
                    end
                    default: ;
                endcase
            end
            vurp_pkg::OP_WRITE: begin
                case (it.reg_index)
                    vurp_pkg::REG_CTRL: begin
                        ctrl_q = d;
                        vtmp_q[11:10] = d[1:0];
                    end
                    vurp_pkg::REG_MASK: mask_q = d;
                    vurp_pkg::REG_OAMADDR: oam_addr_q = d;
                    vurp_pkg::REG_OAMDATA: begin
                        oam_mem[oam_addr_q] = d;
                        oam_seen[oam_addr_q] = 1'b1;
                        oam_addr_q = oam_addr_q + 8'd1;
                    end
                    vurp_pkg::REG_SCROLL: begin
                        if (!toggle_q) begin
                            fine_x_q = d[2:0];
                            vtmp_q[4:0] = d[7:3];
                        end else begin
                            vtmp_q[14:12] = d[2:0];
                            vtmp_q[9:5] = d[7:3];
                        end
                        toggle_q = ~toggle_q;
                    end
                    vurp_pkg::REG_ADDR: begin
                        if (!toggle_q) begin
                            vtmp_q = {1'b0, d[5:0], vtmp_q[7:0]};
                        end else begin
                            vtmp_q[7:0] = d;
                            vcur_q = vtmp_q;
                        end
                        toggle_q = ~toggle_q;
                    end
                    vurp_pkg::REG_DATA: begin
                        vram_store(a, d);
                        step_vaddr();
                    end
                    default: ;
                endcase
            end
            vurp_pkg::OP_VBL_SET: begin
                status_q[2] = 1'b1;
                res.nmi_raise = ctrl_q[7];
            end
            default: status_q = 3'b000;
        endcase
        return res;
    endfunction

    // queue one bus item; reads of never-written memory turn into writes
    task automatic issue(logic [1:0] op, logic [2:0] r, logic [7:0] d);
        vurp_pkg::t_in_item it;
        if (op == vurp_pkg::OP_READ && r == vurp_pkg::REG_DATA && !vram_known(vcur_q[13:0]))
            op = vurp_pkg::OP_WRITE;
        if (op == vurp_pkg::OP_READ && r == vurp_pkg::REG_OAMDATA && !oam_seen[oam_addr_q])
            op = vurp_pkg::OP_WRITE;
        it.opcode = op;
        it.reg_index = r;
        it.write_data = d;
        bus_items.push_back(it);
        expected_results.push_back(port_access(it));
        items_queued++;
    endtask

    task automatic point_vaddr(logic [13:0] a);
        issue(vurp_pkg::OP_READ, vurp_pkg::REG_STATUS, 8'($urandom));
        issue(vurp_pkg::OP_WRITE, vurp_pkg::REG_ADDR, {2'($urandom), a[13:8]});
        issue(vurp_pkg::OP_WRITE, vurp_pkg::REG_ADDR, a[7:0]);
    endtask

    task automatic write_mirror(logic [1:0] m);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= m;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        mirror_sel = m;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        wait (bus_items.size() == 0 && expected_results.size() == 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic random_traffic(int count);
        int stop, r, k;
        logic [13:0] a;
        stop = items_queued + count;
        while (items_queued < stop) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                k = $urandom_range(1, 6);
                case ($urandom_range(0, 2))
                    0: a = 14'($urandom_range(0, 14'h1FFF));
                    1: a = 14'($urandom_range(14'h2000, 14'h3EFF));
                    default: a = 14'($urandom_range(14'h3F00, 14'h3FFF));
                endcase
                if ($urandom_range(0, 2) == 0)
                    issue(vurp_pkg::OP_WRITE, vurp_pkg::REG_CTRL, 8'($urandom));
                if ($urandom_range(0, 3) == 0)
                    issue(vurp_pkg::OP_WRITE, vurp_pkg::REG_MASK, 8'($urandom));
                point_vaddr(a);
                repeat (k) issue(vurp_pkg::OP_WRITE, vurp_pkg::REG_DATA, 8'($urandom));
                point_vaddr(a);
                repeat (k + 1) issue(vurp_pkg::OP_READ, vurp_pkg::REG_DATA, 8'($urandom));
            end else if (r < 55) begin
                k = $urandom_range(1, 5);
                a = 14'($urandom);
                issue(vurp_pkg::OP_WRITE, vurp_pkg::REG_OAMADDR, a[7:0]);
                repeat (k) issue(vurp_pkg::OP_WRITE, vurp_pkg::REG_OAMDATA, 8'($urandom));
                issue(vurp_pkg::OP_WRITE, vurp_pkg::REG_OAMADDR, a[7:0]);
                repeat (k) issue(vurp_pkg::OP_READ, vurp_pkg::REG_OAMDATA, 8'($urandom));
                issue(vurp_pkg::OP_READ, vurp_pkg::REG_OAMADDR, 8'($urandom));
            end else if (r < 65) begin
                issue(vurp_pkg::OP_WRITE, vurp_pkg::REG_SCROLL, 8'($urandom));
                issue(vurp_pkg::OP_WRITE, vurp_pkg::REG_SCROLL, 8'($urandom));
            end else if (r < 78) begin
                issue(2'($urandom_range(vurp_pkg::OP_VBL_SET, vurp_pkg::OP_VBL_CLR)),
                      3'($urandom), 8'($urandom));
                issue(vurp_pkg::OP_READ, vurp_pkg::REG_STATUS, 8'($urandom));
            end else begin
                issue(2'($urandom), 3'($urandom), 8'($urandom));
            end
        end
    endtask

    task automatic report_mismatch(string field, int got, int want);
        errors++;
        $display("mismatch on result %0d: %s got 0x%0h, expected 0x%0h",
                 results_checked, field, got, want);
    endtask

    // driver
    always @(posedge i_clk) in_taken = i_rst_n && i_in_valid && !o_in_stall;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (in_taken) void'(bus_items.pop_front());
            if (in_gap > 0) begin
                in_gap--;
                i_in_valid <= 1'b0;
            end else if (bus_items.size() > 0) begin
                i_in_valid <= 1'b1;
                i_in_item <= bus_items[0];
                in_gap = pick_gap();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (out_gap > 0) begin
            out_gap--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
            out_gap = pick_gap();
        end
    end

    // monitor
    always @(posedge i_clk) begin
        vurp_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected item", o_out_item, 0);
            end else begin
                want = expected_results.pop_front();
                if (o_out_item.read_data !== want.read_data)
                    report_mismatch("read_data", o_out_item.read_data, want.read_data);
                if (o_out_item.nmi_raise !== want.nmi_raise)
                    report_mismatch("nmi_raise", o_out_item.nmi_raise, want.nmi_raise);
                if (want.nmi_raise) nmi_count++;
            end
            results_checked++;
        end
    end

    initial begin
        logic [1:0] modes [6];
        modes = '{2'd0, 2'd3, 2'd1, 2'd2, 2'd1, 2'd0};
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = 2'd0;
        {mirror_sel, ctrl_q, mask_q, rbuf_q, oam_addr_q} = '0;
        {status_q, fine_x_q, vcur_q, vtmp_q, toggle_q} = '0;
        in_gap = 0;
        out_gap = 0;
        calm = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        write_mirror(modes[0]);
        // directed opening
        issue(vurp_pkg::OP_READ, vurp_pkg::REG_CTRL, 8'hFF);
        issue(vurp_pkg::OP_READ, vurp_pkg::REG_MASK, 8'h00);
        issue(vurp_pkg::OP_READ, vurp_pkg::REG_SCROLL, 8'h00);
        issue(vurp_pkg::OP_READ, vurp_pkg::REG_ADDR, 8'h00);
        issue(vurp_pkg::OP_WRITE, vurp_pkg::REG_STATUS, 8'hFF);
        issue(vurp_pkg::OP_WRITE, vurp_pkg::REG_CTRL, 8'h80);
        issue(vurp_pkg::OP_VBL_SET, vurp_pkg::REG_CTRL, 8'h00);
        issue(vurp_pkg::OP_READ, vurp_pkg::REG_STATUS, 8'h00);
        issue(vurp_pkg::OP_VBL_SET, vurp_pkg::REG_DATA, 8'hFF);
        issue(vurp_pkg::OP_VBL_CLR, vurp_pkg::REG_DATA, 8'hFF);
        issue(vurp_pkg::OP_READ, vurp_pkg::REG_STATUS, 8'h00);
        issue(vurp_pkg::OP_WRITE, vurp_pkg::REG_OAMADDR, 8'hFF);
        issue(vurp_pkg::OP_WRITE, vurp_pkg::REG_OAMDATA, 8'hA5);
        issue(vurp_pkg::OP_WRITE, vurp_pkg::REG_OAMDATA, 8'h5A);
        issue(vurp_pkg::OP_WRITE, vurp_pkg::REG_OAMADDR, 8'hFF);
        issue(vurp_pkg::OP_READ, vurp_pkg::REG_OAMDATA, 8'h00);
        issue(vurp_pkg::OP_WRITE, vurp_pkg::REG_SCROLL, 8'hFF);
        issue(vurp_pkg::OP_WRITE, vurp_pkg::REG_SCROLL, 8'hFF);
        point_vaddr(14'h3F10);
        issue(vurp_pkg::OP_WRITE, vurp_pkg::REG_DATA, 8'hFF);
        issue(vurp_pkg::OP_WRITE, vurp_pkg::REG_MASK, 8'h01);
        point_vaddr(14'h3F00);
        issue(vurp_pkg::OP_READ, vurp_pkg::REG_DATA, 8'h00);
        issue(vurp_pkg::OP_WRITE, vurp_pkg::REG_CTRL, 8'h04);
        issue(vurp_pkg::OP_WRITE, vurp_pkg::REG_ADDR, 8'hFF);
        issue(vurp_pkg::OP_WRITE, vurp_pkg::REG_ADDR, 8'hFF);
        issue(vurp_pkg::OP_WRITE, vurp_pkg::REG_DATA, 8'h00);
        issue(vurp_pkg::OP_WRITE, vurp_pkg::REG_CTRL, 8'h00);

        foreach (modes[p]) begin
            if (p > 0) begin
                settle();
                write_mirror(modes[p]);
            end
            calm = (p == 2);
            random_traffic(PHASE_ITEMS);
        end
        settle();
        repeat (20) @(posedge i_clk);

        $display("covered %0d bus items and %0d results over %0d mirroring phases",
                 items_queued, results_checked, $size(modes));
        $display("nmi raised %0d times, %0d mismatches", nmi_count, errors);
        if (errors == 0)
            $display("video_unit_register_port_and_vram_map_core test passed");
        else
            $display("video_unit_register_port_and_vram_map_core test failed");
        $finish;
    end
endmodule
